FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the spring force core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSF_ASSUME_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DSF_ASSERT(label, clk, rst_n, prop, msg)
`define DSF_ASSUME_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/dsf_pkg.sv
// Types, constants and helper functions of the damped spring force core.
package dsf_pkg;

  localparam int DW       = 32;
  localparam int FB       = 16;
  localparam int DIFF_W   = DW + 1;
  localparam int MAG_W    = DW + 1;
  localparam int SUM_W    = 2 * MAG_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_PER   = 3;
  localparam int SQ_STAGES = ROOT_W / SQ_PER;
  localparam int QW       = FB + 1;
  localparam int DV_PER   = 3;
  localparam int DV_STAGES = (QW + DV_PER - 1) / DV_PER;
  localparam int DREM_W   = ROOT_W + 1;
  localparam int REST_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int PIPE_LAT = 3 + SQ_STAGES + 1 + DV_STAGES + 6;

  localparam logic signed [63:0] DW_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] DW_MIN = -DW_MAX - 64'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRING  = 2'd0,
    CFG_DAMPING = 2'd1,
    CFG_REST    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                     vld;
    logic                     deg;
    logic [SUM_W-1:0]         x;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    logic [2:0]               dneg;
    logic [2:0][MAG_W-1:0]    dmag;
    logic [2:0][DIFF_W-1:0]   vel;
  } sq_t;

  typedef struct packed {
    logic                     vld;
    logic                     deg;
    logic [ROOT_W-1:0]        len;
    logic [2:0]               dneg;
    logic [2:0][QW-1:0]       nbits;
    logic [2:0][DREM_W-1:0]   rem;
    logic [2:0][QW-1:0]       quo;
    logic [2:0][DIFF_W-1:0]   vel;
  } dv_t;

  function automatic logic signed [DW-1:0] clamp_dw(input logic signed [63:0] v);
    if (v > DW_MAX) return DW_MAX[DW-1:0];
    if (v < DW_MIN) return DW_MIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic ovf_dw(input logic signed [63:0] v);
    return (v > DW_MAX) || (v < DW_MIN);
  endfunction

endpackage

FILE: rtl/damped_spring_force_core.sv
// Pipelined damped spring force between two particles, Q16.16 fixed point.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  item in | start / busy              | first_*/second_* pos and vel x, y, z
//  result  | done_o strobe (no stall)  | force_x/y/z_o, degenerate_o, saturated_o
//  config  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pair enters every cycle; busy stays low and cfg_ready_o stays high.
// The result strobes done_o once its transfer has passed the input registers,
// the square root pipeline (three rounds a stage), the divider pipeline (three
// quotient bits a stage) and the force registers. Reset clears the valid bits
// and the registers. The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"
module damped_spring_force_core
  import dsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] first_pos_x_i,
  input  logic signed [DW-1:0] first_pos_y_i,
  input  logic signed [DW-1:0] first_pos_z_i,
  input  logic signed [DW-1:0] first_vel_x_i,
  input  logic signed [DW-1:0] first_vel_y_i,
  input  logic signed [DW-1:0] first_vel_z_i,
  input  logic signed [DW-1:0] second_pos_x_i,
  input  logic signed [DW-1:0] second_pos_y_i,
  input  logic signed [DW-1:0] second_pos_z_i,
  input  logic signed [DW-1:0] second_vel_x_i,
  input  logic signed [DW-1:0] second_vel_y_i,
  input  logic signed [DW-1:0] second_vel_z_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DW-1:0]        cfg_data_i,
  output logic                 done_o,
  output logic signed [DW-1:0] force_x_o,
  output logic signed [DW-1:0] force_y_o,
  output logic signed [DW-1:0] force_z_o,
  output logic                 degenerate_o,
  output logic                 saturated_o
);

  logic signed [DW-1:0]     k_q, c_q;
  logic [REST_W-1:0]        rest_q;

  logic [2:0][DW-1:0]       p1, v1, p2, v2;
  logic                     vld_a_q;
  logic [2:0][DIFF_W-1:0]   d_a_d, d_a_q, v_a_d, v_a_q;
  logic                     vld_b_q;
  logic [2:0]               dneg_b_d, dneg_b_q;
  logic [2:0][MAG_W-1:0]    dmag_b_d, dmag_b_q;
  logic [2:0][SUM_W-1:0]    sq_b_d, sq_b_q;
  logic [2:0][DIFF_W-1:0]   v_b_q;
  sq_t                      sq_c_d;
  sq_t                      sq_q [SQ_STAGES+1];
  sq_t                      sq_d [SQ_STAGES];
  dv_t                      dv_0_d;
  dv_t                      dv_q [DV_STAGES+1];
  dv_t                      dv_d [DV_STAGES];

  logic                     vld_p_q, deg_p_q;
  logic [2:0][QW:0]         a_p_d, a_p_q;
  logic [2:0][DIFF_W+QW:0]  prod_p_d, prod_p_q;
  logic signed [ROOT_W+1:0] pert_p_d, pert_p_q;

  logic                     vld_q_q, deg_q_q, sat_q_d, sat_q_q;
  logic [2:0][QW:0]         a_q_q;
  logic signed [DW-1:0]     ax_q_d, ax_q_q, pc_q_d, pc_q_q;
  logic signed [DIFF_W+QW+2:0] axsum;
  logic signed [DIFF_W+QW+2-FB:0] axsh;

  logic                     vld_r_q, deg_r_q, sat_r_q;
  logic [2:0][QW:0]         a_r_q;
  logic signed [2*DW-1:0]   kp_r_d, kp_r_q, cw_r_d, cw_r_q;

  logic                     vld_s_q, deg_s_q, sat_s_d, sat_s_q;
  logic [2:0][QW:0]         a_s_q;
  logic signed [2*DW-FB:0]  str_sum;
  logic signed [DW-1:0]     str_s_d, str_s_q;

  logic                     vld_t_q, deg_t_q, sat_t_q;
  logic [2:0][DW+QW:0]      fp_t_d, fp_t_q;

  logic [2:0][DW-1:0]       f_u_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      c_q    <= '0;
      rest_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPRING:  k_q    <= cfg_data_i;
        CFG_DAMPING: c_q    <= cfg_data_i;
        CFG_REST:    rest_q <= cfg_data_i[REST_W-1:0];
        default:     ;
      endcase
    end
  end

  assign p1 = {first_pos_z_i, first_pos_y_i, first_pos_x_i};
  assign v1 = {first_vel_z_i, first_vel_y_i, first_vel_x_i};
  assign p2 = {second_pos_z_i, second_pos_y_i, second_pos_x_i};
  assign v2 = {second_vel_z_i, second_vel_y_i, second_vel_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_a_d[i] = {p1[i][DW-1], p1[i]} - {p2[i][DW-1], p2[i]};
      v_a_d[i] = {v1[i][DW-1], v1[i]} - {v2[i][DW-1], v2[i]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg_b_d[i] = d_a_q[i][DIFF_W-1];
      dmag_b_d[i] = dneg_b_d[i] ? (~d_a_q[i] + 1'b1) : d_a_q[i];
      sq_b_d[i]   = {{MAG_W{1'b0}}, dmag_b_d[i]} * {{MAG_W{1'b0}}, dmag_b_d[i]};
    end
  end

  always_comb begin
    sq_c_d      = '0;
    sq_c_d.vld  = vld_b_q;
    sq_c_d.x    = sq_b_q[0] + sq_b_q[1] + sq_b_q[2];
    sq_c_d.deg  = (sq_c_d.x == '0);
    sq_c_d.dneg = dneg_b_q;
    sq_c_d.dmag = dmag_b_q;
    sq_c_d.vel  = v_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      sq_q[0]  <= '0;
      d_a_q    <= '0;
      v_a_q    <= '0;
      dneg_b_q <= '0;
      dmag_b_q <= '0;
      sq_b_q   <= '0;
      v_b_q    <= '0;
    end else begin
      vld_a_q  <= start && !busy;
      d_a_q    <= d_a_d;
      v_a_q    <= v_a_d;
      vld_b_q  <= vld_a_q;
      dneg_b_q <= dneg_b_d;
      dmag_b_q <= dmag_b_d;
      sq_b_q   <= sq_b_d;
      v_b_q    <= v_a_q;
      sq_q[0]  <= sq_c_d;
    end
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
    always_comb begin
      logic [REM_W+1:0] r;
      logic [REM_W+1:0] trial;
      sq_d[s] = sq_q[s];
      for (int j = 0; j < SQ_PER; j++) begin
        r     = {sq_d[s].rem, sq_d[s].x[SUM_W-1 -: 2]};
        trial = {1'b0, sq_d[s].root, 2'b01};
        if (r >= trial) begin
          r            = r - trial;
          sq_d[s].root = {sq_d[s].root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_d[s].root = {sq_d[s].root[ROOT_W-2:0], 1'b0};
        end
        sq_d[s].rem = r[REM_W-1:0];
        sq_d[s].x   = {sq_d[s].x[SUM_W-3:0], 2'b00};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[s+1] <= '0;
      end else begin
        sq_q[s+1] <= sq_d[s];
      end
    end
  end

  always_comb begin
    dv_0_d      = '0;
    dv_0_d.vld  = sq_q[SQ_STAGES].vld;
    dv_0_d.deg  = sq_q[SQ_STAGES].deg;
    dv_0_d.len  = sq_q[SQ_STAGES].root;
    dv_0_d.dneg = sq_q[SQ_STAGES].dneg;
    dv_0_d.vel  = sq_q[SQ_STAGES].vel;
    for (int i = 0; i < 3; i++) begin
      dv_0_d.rem[i]   = {2'b00, sq_q[SQ_STAGES].dmag[i][MAG_W-1:1]};
      dv_0_d.nbits[i] = {sq_q[SQ_STAGES].dmag[i][0], {FB{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else begin
      dv_q[0] <= dv_0_d;
    end
  end

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_div
    always_comb begin
      logic [DREM_W-1:0] r;
      dv_d[s] = dv_q[s];
      for (int j = 0; j < DV_PER; j++) begin
        if (s * DV_PER + j < QW) begin
          for (int i = 0; i < 3; i++) begin
            r = {dv_d[s].rem[i][DREM_W-2:0], dv_d[s].nbits[i][QW-1]};
            if (r >= {1'b0, dv_d[s].len}) begin
              r                 = r - {1'b0, dv_d[s].len};
              dv_d[s].quo[i]    = {dv_d[s].quo[i][QW-2:0], 1'b1};
            end else begin
              dv_d[s].quo[i]    = {dv_d[s].quo[i][QW-2:0], 1'b0};
            end
            dv_d[s].rem[i]   = r;
            dv_d[s].nbits[i] = {dv_d[s].nbits[i][QW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= '0;
      end else begin
        dv_q[s+1] <= dv_d[s];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_p_d[i]    = dv_q[DV_STAGES].dneg[i] ? (~{1'b0, dv_q[DV_STAGES].quo[i]} + 1'b1)
                                             : {1'b0, dv_q[DV_STAGES].quo[i]};
      prod_p_d[i] = $signed(a_p_d[i]) * $signed(dv_q[DV_STAGES].vel[i]);
    end
    pert_p_d = $signed({2'b00, dv_q[DV_STAGES].len}) - $signed({4'b0000, rest_q});
  end

  always_comb begin
    axsum  = $signed(prod_p_q[0]) + $signed(prod_p_q[1]) + $signed(prod_p_q[2]);
    axsh   = axsum[DIFF_W+QW+2:FB];
    ax_q_d = clamp_dw(64'(axsh));
    pc_q_d = clamp_dw(64'(pert_p_q));
    sat_q_d = ovf_dw(64'(axsh)) || ovf_dw(64'(pert_p_q));
  end

  assign kp_r_d = k_q * pc_q_q;
  assign cw_r_d = c_q * ax_q_q;

  always_comb begin
    str_sum = (2*DW-FB+1)'(kp_r_q >>> FB) + (2*DW-FB+1)'(cw_r_q >>> FB);
    str_s_d = clamp_dw(64'(str_sum));
    sat_s_d = sat_r_q || ovf_dw(64'(str_sum));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fp_t_d[i] = str_s_q * $signed(a_s_q[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_u_d[i] = deg_t_q ? '0 : fp_t_q[i][FB +: DW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0; deg_p_q <= 1'b0; a_p_q <= '0; prod_p_q <= '0; pert_p_q <= '0;
      vld_q_q <= 1'b0; deg_q_q <= 1'b0; sat_q_q <= 1'b0; a_q_q <= '0;
      ax_q_q  <= '0;   pc_q_q  <= '0;
      vld_r_q <= 1'b0; deg_r_q <= 1'b0; sat_r_q <= 1'b0; a_r_q <= '0;
      kp_r_q  <= '0;   cw_r_q  <= '0;
      vld_s_q <= 1'b0; deg_s_q <= 1'b0; sat_s_q <= 1'b0; a_s_q <= '0; str_s_q <= '0;
      vld_t_q <= 1'b0; deg_t_q <= 1'b0; sat_t_q <= 1'b0; fp_t_q <= '0;
      done_o  <= 1'b0; degenerate_o <= 1'b0; saturated_o <= 1'b0;
      force_x_o <= '0; force_y_o <= '0; force_z_o <= '0;
    end else begin
      vld_p_q  <= dv_q[DV_STAGES].vld;
      deg_p_q  <= dv_q[DV_STAGES].deg;
      a_p_q    <= a_p_d;
      prod_p_q <= prod_p_d;
      pert_p_q <= pert_p_d;
      vld_q_q  <= vld_p_q;
      deg_q_q  <= deg_p_q;
      sat_q_q  <= sat_q_d;
      a_q_q    <= a_p_q;
      ax_q_q   <= ax_q_d;
      pc_q_q   <= pc_q_d;
      vld_r_q  <= vld_q_q;
      deg_r_q  <= deg_q_q;
      sat_r_q  <= sat_q_q;
      a_r_q    <= a_q_q;
      kp_r_q   <= kp_r_d;
      cw_r_q   <= cw_r_d;
      vld_s_q  <= vld_r_q;
      deg_s_q  <= deg_r_q;
      sat_s_q  <= sat_s_d;
      a_s_q    <= a_r_q;
      str_s_q  <= str_s_d;
      vld_t_q  <= vld_s_q;
      deg_t_q  <= deg_s_q;
      sat_t_q  <= sat_s_q;
      fp_t_q   <= fp_t_d;
      done_o       <= vld_t_q;
      degenerate_o <= deg_t_q;
      saturated_o  <= sat_t_q && !deg_t_q;
      force_x_o    <= f_u_d[0];
      force_y_o    <= f_u_d[1];
      force_z_o    <= f_u_d[2];
    end
  end

  `DSF_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##PIPE_LAT done_o, "result strobe missing after pipeline latency")
  `DSF_ASSUME_NEVER(a_deg_sat, clk_i, rst_ni, done_o && degenerate_o && saturated_o, "degenerate result flagged saturated")
  `DSF_ASSERT(a_deg_zero, clk_i, rst_ni, (done_o && degenerate_o) |-> (force_x_o == '0 && force_y_o == '0 && force_z_o == '0), "degenerate result has nonzero force")

endmodule
